### rtl/mcr_pkg.sv
package mcr_pkg;

    localparam int COORD_W = 8;
    localparam int COLOR_W = 16;
    localparam int XPOS_W  = 9;
    localparam int YPOS_W  = 10;
    localparam int DEC_W   = 12;
    localparam int IDX_W   = 3;

    // request kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // drawing modes
    localparam logic MODE_OUTLINE = 1'b0;
    localparam logic MODE_FILL    = 1'b1;

    // index of the final primitive of a step
    localparam logic [IDX_W-1:0] LAST_OUTLINE = 3'd7;
    localparam logic [IDX_W-1:0] LAST_FILL    = 3'd1;

    // one iteration snapshot handed from the walker to the emitter
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COLOR_W-1:0] color;
        logic               fill;
        logic               done;
    } job_t;

    typedef struct packed {
        logic active;
    } walk_status_t;

    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] idx;
    } emit_status_t;

endpackage

### rtl/mcr_req_if.sv
interface mcr_req_if;
    import mcr_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] radius;
    logic [COLOR_W-1:0] pen_color;
    logic               fill_mode;

    modport source (
        output valid, kind, center_x, center_y, radius, pen_color, fill_mode,
        input  ready
    );

    modport sink (
        input  valid, kind, center_x, center_y, radius, pen_color, fill_mode,
        output ready
    );
endinterface

### rtl/mcr_res_if.sv
interface mcr_res_if;
    import mcr_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [COORD_W-1:0] out_height;
    logic [COORD_W-1:0] out_width;
    logic [COLOR_W-1:0] out_color;
    logic               step_last;
    logic               circle_done;

    modport source (
        output valid, out_x, out_y, out_height, out_width, out_color,
               step_last, circle_done,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_height, out_width, out_color,
               step_last, circle_done,
        output ready
    );
endinterface

### rtl/mcr_walker.sv
module mcr_walker (
    input  logic                  clk,
    input  logic                  rst_n,
    mcr_req_if.sink               req,
    input  logic                  job_ready,
    output logic                  job_load,
    output mcr_pkg::job_t         job,
    output mcr_pkg::walk_status_t status
);
    import mcr_pkg::*;

    logic [XPOS_W-1:0]  cur_x_reg, cur_x_next;
    logic [YPOS_W-1:0]  cur_y_reg, cur_y_next;
    logic [DEC_W-1:0]   decision_reg, decision_next;
    logic [COORD_W-1:0] centre_col_reg, centre_col_next;
    logic [COORD_W-1:0] centre_row_reg, centre_row_next;
    logic [COLOR_W-1:0] held_color_reg, held_color_next;
    logic               held_fill_reg, held_fill_next;
    logic               active_reg, active_next;

    logic               accept;
    logic               step_go;
    logic [DEC_W-1:0]   x_ext;
    logic [DEC_W-1:0]   y_ext;
    logic [DEC_W-1:0]   diff;
    logic [DEC_W-1:0]   dec_neg;
    logic [DEC_W-1:0]   dec_pos;
    logic [XPOS_W-1:0]  x_inc;
    logic [YPOS_W-1:0]  y_upd;
    logic               done;

    assign req.ready = job_ready;
    assign accept    = req.valid && job_ready;
    assign step_go   = accept && (req.kind == KIND_STEP) && active_reg;
    assign job_load  = step_go;

    // one midpoint iteration; the decision arithmetic is in 12-bit two's complement
    always_comb
    begin
        x_ext   = {{(DEC_W-XPOS_W){1'b0}}, cur_x_reg};
        y_ext   = {{(DEC_W-YPOS_W){cur_y_reg[YPOS_W-1]}}, cur_y_reg};
        diff    = x_ext - y_ext;
        dec_neg = decision_reg + {x_ext[DEC_W-3:0], 2'b00} + 12'd6;
        dec_pos = decision_reg + {diff[DEC_W-3:0], 2'b00} + 12'd10;
        x_inc   = cur_x_reg + 9'd1;
        y_upd   = decision_reg[DEC_W-1] ? cur_y_reg : (cur_y_reg - 10'd1);
        done    = $signed({2'b00, x_inc}) > $signed({y_upd[YPOS_W-1], y_upd});
    end

    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        decision_next   = decision_reg;
        centre_col_next = centre_col_reg;
        centre_row_next = centre_row_reg;
        held_color_next = held_color_reg;
        held_fill_next  = held_fill_reg;
        active_next     = active_reg;
        if (accept && (req.kind == KIND_START))
        begin
            cur_x_next      = '0;
            cur_y_next      = {2'b00, req.radius};
            decision_next   = 12'd3 - {3'b000, req.radius, 1'b0};
            centre_col_next = req.center_x;
            centre_row_next = req.center_y;
            held_color_next = req.pen_color;
            held_fill_next  = req.fill_mode;
            active_next     = 1'b1;
        end
        else if (step_go)
        begin
            cur_x_next    = x_inc;
            cur_y_next    = y_upd;
            decision_next = decision_reg[DEC_W-1] ? dec_neg : dec_pos;
            active_next   = !done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            decision_reg   <= '0;
            centre_col_reg <= '0;
            centre_row_reg <= '0;
            held_color_reg <= '0;
            held_fill_reg  <= 1'b0;
            active_reg     <= 1'b0;
        end
        else
        begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            decision_reg   <= decision_next;
            centre_col_reg <= centre_col_next;
            centre_row_reg <= centre_row_next;
            held_color_reg <= held_color_next;
            held_fill_reg  <= held_fill_next;
            active_reg     <= active_next;
        end
    end

    // snapshot of the pre-step position
    always_comb
    begin
        job.x     = cur_x_reg[COORD_W-1:0];
        job.y     = cur_y_reg[COORD_W-1:0];
        job.cx    = centre_col_reg;
        job.cy    = centre_row_reg;
        job.color = held_color_reg;
        job.fill  = held_fill_reg;
        job.done  = done;
    end

    assign status.active = active_reg;

endmodule

### rtl/mcr_emitter.sv
module mcr_emitter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_load,
    input  mcr_pkg::job_t         job,
    output logic                  job_ready,
    mcr_res_if.source             res,
    output mcr_pkg::emit_status_t status
);
    import mcr_pkg::*;

    job_t               job_reg, job_next;
    logic               busy_reg, busy_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;

    logic [COORD_W-1:0] x_reg, y_reg, h_reg, w_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               last_reg, done_reg;

    logic               emit;
    logic               is_last;
    logic [IDX_W-1:0]   last_idx;
    logic [COORD_W-1:0] px, py, ph, pw;
    logic [COORD_W-1:0] xa, xs, ya, ys, xay, xsy, yax, ysx;

    assign last_idx  = (job_reg.fill == MODE_FILL) ? LAST_FILL : LAST_OUTLINE;
    assign is_last   = (idx_reg == last_idx);
    assign emit      = busy_reg && (!out_valid_reg || res.ready);
    assign job_ready = !busy_reg || (emit && is_last);

    always_comb
    begin
        xa  = job_reg.cx + job_reg.x;
        xs  = job_reg.cx - job_reg.x;
        ya  = job_reg.cy + job_reg.y;
        ys  = job_reg.cy - job_reg.y;
        xay = job_reg.cx + job_reg.y;
        xsy = job_reg.cx - job_reg.y;
        yax = job_reg.cy + job_reg.x;
        ysx = job_reg.cy - job_reg.x;
        px  = xa;
        py  = ya;
        ph  = 8'd1;
        pw  = 8'd1;
        if (job_reg.fill == MODE_FILL)
        begin
            if (idx_reg == '0)
            begin
                px = xs;
                py = ys;
                ph = {job_reg.y[COORD_W-2:0], 1'b0};
                pw = {job_reg.x[COORD_W-2:0], 1'b0};
            end
            else
            begin
                px = xsy;
                py = ysx;
                ph = {job_reg.x[COORD_W-2:0], 1'b0};
                pw = {job_reg.y[COORD_W-2:0], 1'b0};
            end
        end
        else
        begin
            unique case (idx_reg)
                3'd0:    begin px = xa;  py = ya;  end
                3'd1:    begin px = xa;  py = ys;  end
                3'd2:    begin px = xs;  py = ya;  end
                3'd3:    begin px = xs;  py = ys;  end
                3'd4:    begin px = xay; py = yax; end
                3'd5:    begin px = xay; py = ysx; end
                3'd6:    begin px = xsy; py = yax; end
                default: begin px = xsy; py = ysx; end
            endcase
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        job_next  = job_reg;
        if (emit)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
                idx_next  = '0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
        if (job_load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            job_next  = job;
        end
        if (emit)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (emit)
        begin
            x_reg     <= px;
            y_reg     <= py;
            h_reg     <= ph;
            w_reg     <= pw;
            color_reg <= job_reg.color;
            last_reg  <= is_last;
            done_reg  <= is_last && job_reg.done;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.out_x       = x_reg;
    assign res.out_y       = y_reg;
    assign res.out_height  = h_reg;
    assign res.out_width   = w_reg;
    assign res.out_color   = color_reg;
    assign res.step_last   = last_reg;
    assign res.circle_done = done_reg;

    assign status.busy = busy_reg;
    assign status.idx  = idx_reg;

endmodule

### rtl/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer.
// A step request's first primitive reaches res via the emitter snapshot register,
// then its output register. A step emits eight primitives in outline mode and two
// in filled mode, one primitive per cycle while res is ready; a start or idle step emits none.
// Reset (rst_n, async, active low) clears the circle state, leaving no circle active.
module midpoint_circle_rasterizer (
    input  logic      clk,
    input  logic      rst_n,
    mcr_req_if.sink   req,
    mcr_res_if.source res
);
    import mcr_pkg::*;

    // walker -> emitter hand-off of one iteration snapshot
    job_t         job;
    logic         job_load;
    logic         job_ready;
    walk_status_t walk_status;
    emit_status_t emit_status;

    // Walker: hold the circle state, take start and step requests, and advance
    // the decision variable once per step. A request is taken whenever the
    // emitter can accept a new snapshot, so a start can overlap the drain of
    // the previous step.
    mcr_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .job_ready (job_ready),
        .job_load  (job_load),
        .job       (job),
        .status    (walk_status)
    );

    // Emitter: hold one snapshot and walk through its eight points or two
    // rectangles into the output register, one per cycle unless res stalls. The last
    // primitive frees the snapshot slot in the same cycle it is sent.
    mcr_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_load  (job_load),
        .job       (job),
        .job_ready (job_ready),
        .res       (res),
        .status    (emit_status)
    );

`ifndef SYNTHESIS
    // circle completion is only flagged on the closing primitive of a step
    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (!res.circle_done || res.step_last))
        else $error("circle_done without step_last");

    // an accepted start always leaves a circle in progress
    a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.kind == KIND_START) |=> walk_status.active)
        else $error("start did not activate circle");

    // an idle emitter sits at the first primitive index
    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !emit_status.busy |-> (emit_status.idx == '0))
        else $error("idle emitter with nonzero index");

    // a new snapshot only enters when the slot is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        job_load |-> job_ready)
        else $error("snapshot loaded into a busy emitter");
`endif

endmodule
